[src/icmp_erb_pkg.sv]
package icmp_erb_pkg;

  // Default depth of the queue between the byte classifier and the field engine.
  localparam int unsigned QueueDepth = 2;

  localparam logic [15:0] EthertypeIpv4   = 16'h0800;
  localparam logic [15:0] WordMask        = 16'hffff;
  localparam logic [15:0] PosMax          = 16'hffff;
  localparam logic [15:0] EthHeaderBytes  = 16'd14;
  localparam logic [7:0]  IcmpProtocol    = 8'd1;
  localparam logic [6:0]  IcmpHeaderBytes = 7'd8;
  localparam logic [3:0]  MinIhl          = 4'd5;

  // Header field that a frame byte belongs to.
  typedef enum logic [3:0] {
    FieldNone,
    FieldTypeHi,
    FieldTypeLo,
    FieldIhl,
    FieldLenHi,
    FieldLenLo,
    FieldProto,
    FieldSrc,
    FieldDst
  } field_e;

  // One classified frame byte, as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       skip;
    field_e     field;
    logic       in_region;
    logic       high_half;
    logic       zero_byte;
    logic       len_ok;
  } byte_item_t;

  // End-of-frame summary handed from the back to the output stage.
  typedef struct packed {
    logic        ok;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] raw_sum;
    logic [15:0] length;
  } result_t;

endpackage

[src/icmp_erb_front.sv]
module icmp_erb_front
  import icmp_erb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] frame_byte_i,
  input  logic       end_of_frame_i,
  input  logic       q_full_i,
  output logic       push_o,
  output byte_item_t item_o
);

  logic [15:0] pos_q, pos_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [15:0] tl_q, tl_d;

  logic        accept;
  logic        skip;
  field_e      field;
  logic [15:0] region_start;
  logic [15:0] rel;
  logic [16:0] region_end;
  logic [16:0] frame_need;
  logic [16:0] count;
  logic        in_region;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;

  // Bytes past the saturated position are passed on but change nothing.
  assign skip = (pos_q == PosMax);

  // Decode the header field from the byte position.
  always_comb begin
    field = FieldNone;
    if (!skip) begin
      case (pos_q) inside
        16'd12:            field = FieldTypeHi;
        16'd13:            field = FieldTypeLo;
        16'd14:            field = FieldIhl;
        16'd16:            field = FieldLenHi;
        16'd17:            field = FieldLenLo;
        16'd23:            field = FieldProto;
        [16'd26:16'd29]:   field = FieldSrc;
        [16'd30:16'd33]:   field = FieldDst;
        default:           field = FieldNone;
      endcase
    end
  end

  // The ICMP region runs from 14 + IHL*4 up to 14 + total length.
  assign region_start = EthHeaderBytes + {10'd0, ihl_q, 2'b00};
  assign rel          = pos_q - region_start;
  assign region_end   = {1'b0, tl_q} + {1'b0, EthHeaderBytes};
  assign in_region    = !skip && (ihl_q >= MinIhl) && (pos_q >= region_start) &&
                        ({1'b0, pos_q} < region_end);

  // Captured fields after this byte, used for the frame length check.
  always_comb begin
    ihl_d = ihl_q;
    tl_d  = tl_q;
    case (field)
      FieldIhl:   ihl_d = frame_byte_i[3:0];
      FieldLenHi: tl_d  = {frame_byte_i, tl_q[7:0]};
      FieldLenLo: tl_d  = {tl_q[15:8], frame_byte_i};
      default: begin
      end
    endcase
  end

  assign frame_need = {1'b0, tl_d} + {1'b0, EthHeaderBytes};
  assign count      = skip ? {1'b0, pos_q} : ({1'b0, pos_q} + 17'd1);

  always_comb begin
    item_o.data      = frame_byte_i;
    item_o.last      = end_of_frame_i;
    item_o.skip      = skip;
    item_o.field     = field;
    item_o.in_region = in_region;
    item_o.high_half = !pos_q[0];
    item_o.zero_byte = (rel[15:2] == 14'd0) && (rel[1:0] != 2'd1);
    item_o.len_ok    = (count >= frame_need);
  end

  // Position counter and the fields the classifier itself depends on.
  always_comb begin
    pos_d = pos_q;
    if (end_of_frame_i) begin
      pos_d = '0;
    end else if (!skip) begin
      pos_d = pos_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ihl_q <= '0;
      tl_q  <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
      if (end_of_frame_i) begin
        ihl_q <= '0;
        tl_q  <= '0;
      end else begin
        ihl_q <= ihl_d;
        tl_q  <= tl_d;
      end
    end
  end

endmodule

[src/icmp_erb_queue.sv]
module icmp_erb_queue
  import icmp_erb_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  byte_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output byte_item_t item_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  byte_item_t mem_q [DEPTH];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Pointers wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Item storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[src/icmp_erb_back.sv]
module icmp_erb_back
  import icmp_erb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  byte_item_t item_i,
  output logic       pop_o,
  input  logic       res_ready_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic [15:0] ft_q, ft_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [15:0] tl_q, tl_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [31:0] sum_q, sum_d;
  logic [7:0]  held_q, held_d;
  logic        pend_q, pend_d;

  logic [7:0]  sum_byte;
  logic [31:0] addend;
  logic [31:0] sum_plus;
  logic [16:0] min_length;
  logic        ok;

  // A final byte waits until the output stage has room for its result.
  assign pop_o       = valid_i && (!item_i.last || res_ready_i);
  assign res_valid_o = pop_o && item_i.last;

  // Capture header fields.
  always_comb begin
    ft_d    = ft_q;
    ihl_d   = ihl_q;
    tl_d    = tl_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    case (item_i.field)
      FieldTypeHi: ft_d    = {item_i.data, ft_q[7:0]};
      FieldTypeLo: ft_d    = {ft_q[15:8], item_i.data};
      FieldIhl:    ihl_d   = item_i.data[3:0];
      FieldLenHi:  tl_d    = {item_i.data, tl_q[7:0]};
      FieldLenLo:  tl_d    = {tl_q[15:8], item_i.data};
      FieldProto:  proto_d = item_i.data;
      FieldSrc:    src_d   = {src_q[23:0], item_i.data};
      FieldDst:    dst_d   = {dst_q[23:0], item_i.data};
      default: begin
      end
    endcase
  end

  // Word assembly and the running sum. A high byte left over at the end
  // of the frame is padded with a zero low byte through the same adder.
  assign sum_byte = item_i.zero_byte ? 8'd0 : item_i.data;

  always_comb begin
    addend = '0;
    if (item_i.in_region) begin
      if (!item_i.high_half) begin
        addend = {16'd0, held_q, sum_byte};
      end else if (item_i.last) begin
        addend = {16'd0, sum_byte, 8'd0};
      end
    end else if (item_i.last && pend_q) begin
      addend = {16'd0, held_q, 8'd0};
    end
  end

  assign sum_plus = sum_q + addend;

  always_comb begin
    sum_d  = sum_q;
    held_d = held_q;
    pend_d = pend_q;
    if (item_i.in_region) begin
      if (item_i.high_half) begin
        held_d = sum_byte;
        pend_d = 1'b1;
      end else begin
        sum_d  = sum_plus;
        pend_d = 1'b0;
      end
    end
  end

  // Reply check on the fields as they stand after the final byte.
  assign min_length = {11'd0, ihl_d, 2'b00} + {10'd0, IcmpHeaderBytes};
  assign ok = (ft_d == EthertypeIpv4) && (proto_d == IcmpProtocol) &&
              (ihl_d >= MinIhl) && ({1'b0, tl_d} >= min_length) && item_i.len_ok;

  always_comb begin
    res_o.ok      = ok;
    res_o.src     = ok ? dst_d : '0;
    res_o.dst     = ok ? src_d : '0;
    res_o.raw_sum = sum_plus;
    res_o.length  = ok ? (tl_d & WordMask) : '0;
  end

  // Frame state; the final byte clears it for the next frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ft_q    <= '0;
      ihl_q   <= '0;
      tl_q    <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      sum_q   <= '0;
      held_q  <= '0;
      pend_q  <= 1'b0;
    end else if (pop_o) begin
      if (item_i.last) begin
        ft_q    <= '0;
        ihl_q   <= '0;
        tl_q    <= '0;
        proto_q <= '0;
        src_q   <= '0;
        dst_q   <= '0;
        sum_q   <= '0;
        held_q  <= '0;
        pend_q  <= 1'b0;
      end else begin
        ft_q    <= ft_d;
        ihl_q   <= ihl_d;
        tl_q    <= tl_d;
        proto_q <= proto_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
        sum_q   <= sum_d;
        held_q  <= held_d;
        pend_q  <= pend_d;
      end
    end
  end

endmodule

[src/icmp_erb_out.sv]
module icmp_erb_out
  import icmp_erb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        res_valid_i,
  input  result_t     res_i,
  output logic        res_ready_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_reply_o,
  output logic [31:0] reply_source_o,
  output logic [31:0] reply_destination_o,
  output logic [15:0] reply_checksum_o,
  output logic [15:0] packet_length_o
);

  logic        fin_valid_q;
  result_t     fin_q;
  logic        out_valid_q;
  logic        out_free;
  logic        out_load;
  logic [16:0] fold1;
  logic [16:0] fold2;
  logic [15:0] checksum;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = fin_valid_q && out_free;
  assign res_ready_o = !fin_valid_q || out_free;
  assign out_valid_o = out_valid_q;

  // Fold the raw sum twice, then invert.
  assign fold1    = {1'b0, fin_q.raw_sum[31:16]} + {1'b0, fin_q.raw_sum[15:0]};
  assign fold2    = fold1 + {16'd0, fold1[16]};
  assign checksum = fin_q.ok ? (~fold2[15:0] & WordMask) : '0;

  // Summary register between the field engine and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (res_valid_i) begin
      fin_valid_q <= 1'b1;
    end else if (out_load) begin
      fin_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      fin_q <= res_i;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      is_reply_o          <= fin_q.ok;
      reply_source_o      <= fin_q.src;
      reply_destination_o <= fin_q.dst;
      reply_checksum_o    <= checksum;
      packet_length_o     <= fin_q.length;
    end
  end

endmodule

[src/icmp_echo_reply_header_builder_top.sv]
// ICMP echo reply header builder.
// The input channel takes one Ethernet frame byte per item, in wire order,
// with end_of_frame_i marking the final byte. The output channel gives one
// item per frame: the reply flag, the swapped IPv4 addresses, the ICMP
// checksum of the reply and the IP total length (all zero when no reply).
// Both channels move an item at a clock edge where valid is high and stall
// is low.
// Throughput is one byte per cycle unless stalled: the classifier takes a
// byte every cycle while the queue is not full, and the field engine retires
// one queued byte every cycle unless a final byte waits for the output stage.
// A result passes the queue, the summary register and the output register.
// When the receiver stalls, the result holds in the output register, the
// next result waits in the summary register, the final byte of a third frame
// waits at the head of the queue, and in_stall_o rises once the queue fills.
// Reset clears all frame state and empties the queue and output stages.
module icmp_echo_reply_header_builder_top
  import icmp_erb_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        end_of_frame_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_reply_o,
  output logic [31:0] reply_source_o,
  output logic [31:0] reply_destination_o,
  output logic [15:0] reply_checksum_o,
  output logic [15:0] packet_length_o
);

  logic       push;
  logic       q_full;
  logic       q_valid;
  logic       pop;
  byte_item_t push_item;
  byte_item_t head_item;
  logic       res_valid;
  logic       res_ready;
  result_t    res;

  icmp_erb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .frame_byte_i   (frame_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .item_o         (push_item)
  );

  icmp_erb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  icmp_erb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (head_item),
    .pop_o       (pop),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  icmp_erb_out u_out (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .res_valid_i         (res_valid),
    .res_i               (res),
    .res_ready_o         (res_ready),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .is_reply_o          (is_reply_o),
    .reply_source_o      (reply_source_o),
    .reply_destination_o (reply_destination_o),
    .reply_checksum_o    (reply_checksum_o),
    .packet_length_o     (packet_length_o)
  );

endmodule
